// File: hdl/gjc_pkg.sv
// ----------------------------------------------------------------------------
// gjc_pkg: shared types and constants for the Jacobian column builder
// Item structs, opcodes, joint types and the saturation helper.
// ----------------------------------------------------------------------------
package gjc_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned IdxW  = 6;

  localparam logic OP_START = 1'b0;
  localparam logic OP_ROW   = 1'b1;

  localparam logic [1:0] JT_PRISMATIC = 2'd0;
  localparam logic [1:0] JT_REVOLUTE  = 2'd1;
  localparam logic [1:0] JT_CONSTANT  = 2'd2;

  typedef logic signed [WordW-1:0] word_t;

  typedef struct packed {
    logic       opcode;
    logic [1:0] joint_type;
    logic [1:0] row_index;
    word_t      elem_a;
    word_t      elem_b;
    word_t      elem_c;
    word_t      elem_d;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0] column_index;
    word_t           lin_x;
    word_t           lin_y;
    word_t           lin_z;
    word_t           ang_x;
    word_t           ang_y;
    word_t           ang_z;
    logic            saturated;
  } out_item_t;

  // saturate a wide signed sum to one word
  function automatic word_t sat_word(input logic signed [67:0] v, output logic ovf);
    word_t r;
    begin
      ovf = 1'b0;
      r = v[WordW-1:0];
      if (v > 68'sd2147483647) begin
        ovf = 1'b1;
        r = 32'sh7fffffff;
      end else if (v < -68'sd2147483648) begin
        ovf = 1'b1;
        r = 32'sh80000000;
      end
      return r;
    end
  endfunction

endpackage

// File: hdl/gjc_if.sv
// ----------------------------------------------------------------------------
// gjc_in_if / gjc_out_if: valid-ready channels
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
interface gjc_in_if;
  import gjc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gjc_out_if;
  import gjc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/gjc_lane.sv
// ----------------------------------------------------------------------------
// gjc_lane: one row of the chain product
// Registered products, rounded after the register, of one chain row times the
// joint matrix column; the second product can be subtracted instead of added.
// ----------------------------------------------------------------------------
module gjc_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                en,
  input  gjc_pkg::word_t      ta,
  input  gjc_pkg::word_t      tb,
  input  gjc_pkg::word_t      tc,
  input  gjc_pkg::word_t      ma,
  input  gjc_pkg::word_t      mb,
  input  gjc_pkg::word_t      mc,
  input  logic                sub_b,
  input  gjc_pkg::word_t      add,
  output logic signed [67:0]  sum
);
  import gjc_pkg::*;

  logic signed [63:0] pa_r, pb_r, pc_r;
  word_t              add_r;
  logic               sub_r;

  // round half up then floor: arithmetic shift after adding half lsb
  function automatic logic signed [67:0] rnd(input logic signed [63:0] p);
    logic signed [64:0] t;
    begin
      t = {p[63], p} + (65'sd1 <<< (FRAC_BITS - 1));
      return 68'(t >>> FRAC_BITS);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r  <= 64'(ta) * 64'(ma);
      pb_r  <= 64'(tb) * 64'(mb);
      pc_r  <= 64'(tc) * 64'(mc);
      add_r <= add;
      sub_r <= sub_b;
    end
  end

  // rounding happens per product, so a difference negates the rounded term
  assign sum = rnd(pa_r) + (sub_r ? -rnd(pb_r) : rnd(pb_r)) + rnd(pc_r) + 68'(add_r);

endmodule

// File: hdl/geometric_jacobian_columns.sv
// ----------------------------------------------------------------------------
// geometric_jacobian_columns: geometric Jacobian, one column per joint
// A start transfer loads the end-effector position and resets the chain to
// identity. Each joint sends rows 0, 1, 2 of its transform; the row 2
// transfer yields that joint's column from the chain as it was before the
// joint, then the chain is multiplied by the joint matrix. Rows 0 and 1, row
// index 3 and start transfers start no pass. A row 2 transfer keeps the input
// stalled after it is taken for one cross product pass, four column passes
// (three product lanes, one per chain row, one matrix column per cycle) and
// one write-back step where the last lane results land and the result
// register loads. The result is valid from the cycle after write-back. The
// input is also held off while a result waits in the output register and
// the sink does not take it.
// ----------------------------------------------------------------------------
module geometric_jacobian_columns #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned MAX_JOINTS = 64
) (
  input  logic clk,
  input  logic rst_n,
  gjc_in_if.sink    in_ch,
  gjc_out_if.source out_ch
);
  import gjc_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_JOINTS);
  localparam word_t ONE = word_t'(1) <<< FRAC_BITS;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CROSS = 6'b000010,
    S_C0    = 6'b000100,
    S_C1    = 6'b001000,
    S_C2    = 6'b010000,
    S_C3    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  word_t  t_r [12];
  word_t  pe_r [3];
  word_t  rb_r [8];
  word_t  m_r [12];
  word_t  d_r [3];
  word_t  cx_r [3];
  word_t  nt_r [12];
  logic [1:0] jt_r;
  logic   sat_r;
  logic [CntW-1:0] cnt_r;
  logic   full_r;
  logic   ovalid_r;
  out_item_t odata_r;

  // lane outputs are registered: track which pass they belong to
  logic [2:0] pass_r; // 0 none, 1 cross, 2..5 column 0..3
  logic [2:0] pass_nxt;
  logic  fin;

  // lane operand selection
  word_t la [3], lb [3], lc [3], lma [3], lmb [3], lmc [3], ladd [3];
  logic  lsub [3];
  logic signed [67:0] lsum [3];
  word_t lres [3];
  logic  lovf [3];
  logic  busy, accept, lane_en;

  // write-back cycle: chain and result register load from the last pass
  assign fin     = (pass_r == 3'd5);
  assign busy    = (state_r != S_IDLE);
  assign in_ch.ready = !busy && !fin && (!ovalid_r || out_ch.ready);
  assign accept  = in_ch.valid && in_ch.ready;
  assign lane_en = 1'b1;

  // diff pe - p with saturation
  word_t dn [3];
  logic  dovf [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dn[i] = sat_word(68'(pe_r[i]) - 68'(t_r[i*4+3]), dovf[i]);
    end
  end

  // lanes: in S_CROSS lanes compute z x d as (z1*d2 - z2*d1) etc
  // in S_Cn (n=0..3) lane r computes T[r][0..2] dot M[.][n], plus T[r][3] for n=3
  logic [1:0] col_sel;
  always_comb begin
    col_sel = 2'd0;
    unique case (state_r)
      S_C0:    col_sel = 2'd0;
      S_C1:    col_sel = 2'd1;
      S_C2:    col_sel = 2'd2;
      S_C3:    col_sel = 2'd3;
      default: col_sel = 2'd0;
    endcase
    for (int r = 0; r < 3; r++) begin
      la[r]   = t_r[r*4+0];
      lb[r]   = t_r[r*4+1];
      lc[r]   = t_r[r*4+2];
      lma[r]  = m_r[0*4+col_sel];
      lmb[r]  = m_r[1*4+col_sel];
      lmc[r]  = m_r[2*4+col_sel];
      ladd[r] = (col_sel == 2'd3) ? t_r[r*4+3] : '0;
      lsub[r] = 1'b0;
    end
    if (state_r == S_CROSS) begin
      // lin_x = z1*d2 - z2*d1 ; lin_y = z2*d0 - z0*d2 ; lin_z = z0*d1 - z1*d0
      la[0] = t_r[6];  lma[0] = d_r[2];
      lb[0] = t_r[10]; lmb[0] = d_r[1];
      la[1] = t_r[10]; lma[1] = d_r[0];
      lb[1] = t_r[2];  lmb[1] = d_r[2];
      la[2] = t_r[2];  lma[2] = d_r[1];
      lb[2] = t_r[6];  lmb[2] = d_r[0];
      for (int r = 0; r < 3; r++) begin
        lc[r] = '0; lmc[r] = '0; ladd[r] = '0; lsub[r] = 1'b1;
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_lane
      gjc_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
        .clk(clk), .en(lane_en),
        .ta(la[g]), .tb(lb[g]), .tc(lc[g]),
        .ma(lma[g]), .mb(lmb[g]), .mc(lmc[g]),
        .sub_b(lsub[g]), .add(ladd[g]), .sum(lsum[g])
      );
    end
  endgenerate

  always_comb begin
    for (int r = 0; r < 3; r++) lres[r] = sat_word(lsum[r], lovf[r]);
  end

  always_comb begin
    unique case (state_r)
      S_CROSS: pass_nxt = 3'd1;
      S_C0:    pass_nxt = 3'd2;
      S_C1:    pass_nxt = 3'd3;
      S_C2:    pass_nxt = 3'd4;
      S_C3:    pass_nxt = 3'd5;
      default: pass_nxt = 3'd0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept && in_ch.data.opcode == OP_ROW && in_ch.data.row_index == 2'd2)
                 state_nxt = S_CROSS;
      S_CROSS: state_nxt = S_C0;
      S_C0:    state_nxt = S_C1;
      S_C1:    state_nxt = S_C2;
      S_C2:    state_nxt = S_C3;
      S_C3:    state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // chain updates are written back only after the final pass, columns 0..2 held in nt_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pass_r   <= 3'd0;
      ovalid_r <= 1'b0;
      cnt_r    <= '0;
      full_r   <= 1'b0;
      for (int i = 0; i < 12; i++)
        t_r[i] <= (i == 0 || i == 5 || i == 10) ? ONE : '0;
      for (int i = 0; i < 3; i++) pe_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
      if (out_ch.valid && out_ch.ready) ovalid_r <= 1'b0;
      if (accept) begin
        if (in_ch.data.opcode == OP_START) begin
          pe_r[0] <= in_ch.data.elem_a;
          pe_r[1] <= in_ch.data.elem_b;
          pe_r[2] <= in_ch.data.elem_c;
          for (int i = 0; i < 12; i++)
            t_r[i] <= (i == 0 || i == 5 || i == 10) ? ONE : '0;
          cnt_r  <= '0;
          full_r <= 1'b0;
        end
      end
      if (fin) begin
        for (int r = 0; r < 3; r++) begin
          t_r[r*4+0] <= nt_r[r*4+0];
          t_r[r*4+1] <= nt_r[r*4+1];
          t_r[r*4+2] <= nt_r[r*4+2];
          t_r[r*4+3] <= lres[r];
        end
        ovalid_r <= 1'b1;
        if (32'(cnt_r) < MAX_JOINTS - 1) cnt_r <= cnt_r + 1'b1;
        else full_r <= 1'b1;
      end
    end
  end

  // payload registers
  logic sat_any;
  always_comb begin
    sat_any = sat_r;
    for (int r = 0; r < 3; r++) sat_any = sat_any | lovf[r];
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.data.opcode == OP_ROW && in_ch.data.row_index < 2'd2) begin
      for (int i = 0; i < 4; i++) begin
        rb_r[{in_ch.data.row_index[0], 2'(i)}] <= (i == 0) ? in_ch.data.elem_a :
                                                 (i == 1) ? in_ch.data.elem_b :
                                                 (i == 2) ? in_ch.data.elem_c :
                                                            in_ch.data.elem_d;
      end
    end
    if (state_nxt == S_CROSS) begin
      for (int i = 0; i < 8; i++) m_r[i] <= rb_r[i];
      m_r[8]  <= in_ch.data.elem_a;
      m_r[9]  <= in_ch.data.elem_b;
      m_r[10] <= in_ch.data.elem_c;
      m_r[11] <= in_ch.data.elem_d;
      jt_r    <= in_ch.data.joint_type;
      // chain is stable here, so pe - p is ready for the cross pass
      for (int i = 0; i < 3; i++) d_r[i] <= dn[i];
      sat_r   <= (in_ch.data.joint_type == JT_REVOLUTE) && (dovf[0] | dovf[1] | dovf[2]);
    end
    if (pass_r == 3'd1) begin
      for (int r = 0; r < 3; r++) cx_r[r] <= lres[r];
      // cross product overflow only counts for a revolute joint
      if (jt_r == JT_REVOLUTE) sat_r <= sat_any;
    end
    if (pass_r == 3'd2) begin
      for (int r = 0; r < 3; r++) nt_r[r*4+0] <= lres[r];
    end
    if (pass_r == 3'd3) begin
      for (int r = 0; r < 3; r++) nt_r[r*4+1] <= lres[r];
    end
    if (pass_r == 3'd4) begin
      for (int r = 0; r < 3; r++) nt_r[r*4+2] <= lres[r];
    end
    if (pass_r >= 3'd2 && pass_r <= 3'd4) sat_r <= sat_any;
    // result register is empty at write-back: the row 2 transfer needed it so
    if (fin) begin
      odata_r.column_index <= IdxW'(cnt_r);
      odata_r.saturated    <= sat_any | full_r;
      if (jt_r == JT_REVOLUTE) begin
        odata_r.lin_x <= cx_r[0]; odata_r.lin_y <= cx_r[1]; odata_r.lin_z <= cx_r[2];
        odata_r.ang_x <= t_r[2]; odata_r.ang_y <= t_r[6]; odata_r.ang_z <= t_r[10];
      end else if (jt_r == JT_PRISMATIC) begin
        odata_r.lin_x <= t_r[2]; odata_r.lin_y <= t_r[6]; odata_r.lin_z <= t_r[10];
        odata_r.ang_x <= '0; odata_r.ang_y <= '0; odata_r.ang_z <= '0;
      end else begin
        // constant or unset joint
        odata_r.lin_x <= '0; odata_r.lin_y <= '0; odata_r.lin_z <= '0;
        odata_r.ang_x <= '0; odata_r.ang_y <= '0; odata_r.ang_z <= '0;
      end
    end
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = odata_r;

  // ---- assertions ----
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ch.ready) else $error("accepted while busy");
  a_no_accept_fin: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> !in_ch.ready) else $error("accepted during write-back");
  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_result_after_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_C3) |=> !busy) else $error("sequencer overrun");

endmodule

// File: sim/gjc_chk.sv
// ----------------------------------------------------------------------------
// gjc_chk: scoreboard for the Jacobian column builder
// Watches input and result transfers, predicts each column and compares.
// ----------------------------------------------------------------------------
module gjc_chk #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned MAX_JOINTS = 64
) (
  input  logic clk,
  input  logic rst_n,
  gjc_in_if.sink  in_mon,
  gjc_out_if.sink out_mon,
  output int      errors,
  output int      pending
);
  import gjc_pkg::*;

  word_t     chain[12];
  word_t     tip[3];
  word_t     rows[8];
  int unsigned count;
  bit        full;
  out_item_t columns_q[$];

  assign pending = columns_q.size();

  function automatic longint rmul(word_t a, word_t b);
    longint p;
    p = longint'(a) * longint'(b) + (longint'(1) << (FRAC_BITS - 1));
    return p >>> FRAC_BITS;  // arithmetic shift floors
  endfunction

  function automatic word_t clip(longint v, inout bit s);
    if (v > 64'sd2147483647) begin
      s = 1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      s = 1;
      return 32'sh80000000;
    end
    return word_t'(v);
  endfunction

  task automatic reset_chain();
    foreach (chain[i]) chain[i] = '0;
    chain[0] = 1 << FRAC_BITS;
    chain[5] = 1 << FRAC_BITS;
    chain[10] = 1 << FRAC_BITS;
  endtask

  task automatic absorb(in_item_t it);
    word_t m[12], nxt[12], z[3], p[3], d[3], col[6];
    word_t e[4];
    out_item_t o;
    bit s;
    longint acc;
    s = 0;
    e = '{it.elem_a, it.elem_b, it.elem_c, it.elem_d};
    if (it.opcode == OP_START) begin
      tip = '{e[0], e[1], e[2]};
      reset_chain();
      count = 0;
      full = 0;
      return;
    end
    if (it.row_index == 2'd3) return;
    if (it.row_index < 2) begin
      for (int i = 0; i < 4; i++) rows[it.row_index * 4 + i] = e[i];
      return;
    end
    for (int i = 0; i < 8; i++) m[i] = rows[i];
    for (int i = 0; i < 4; i++) m[8 + i] = e[i];
    for (int i = 0; i < 3; i++) begin
      z[i] = chain[i * 4 + 2];
      p[i] = chain[i * 4 + 3];
    end
    foreach (col[i]) col[i] = '0;
    if (it.joint_type == JT_REVOLUTE) begin
      for (int i = 0; i < 3; i++) d[i] = clip(longint'(tip[i]) - longint'(p[i]), s);
      col[0] = clip(rmul(z[1], d[2]) - rmul(z[2], d[1]), s);
      col[1] = clip(rmul(z[2], d[0]) - rmul(z[0], d[2]), s);
      col[2] = clip(rmul(z[0], d[1]) - rmul(z[1], d[0]), s);
      col[3] = z[0];
      col[4] = z[1];
      col[5] = z[2];
    end else if (it.joint_type == JT_PRISMATIC) begin
      col[0] = z[0];
      col[1] = z[1];
      col[2] = z[2];
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += rmul(chain[r * 4 + k], m[k * 4 + c]);
        if (c == 3) acc += longint'(chain[r * 4 + 3]);
        nxt[r * 4 + c] = clip(acc, s);
      end
    chain = nxt;
    if (full) s = 1;
    o.column_index = count[IdxW-1:0];
    if (count < MAX_JOINTS - 1) count++;
    else full = 1;
    o.lin_x = col[0];
    o.lin_y = col[1];
    o.lin_z = col[2];
    o.ang_x = col[3];
    o.ang_y = col[4];
    o.ang_z = col[5];
    o.saturated = s;
    columns_q.push_back(o);
  endtask

  task automatic cmp(string f, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      errors++;
      $error("%s: expected %0d got %0d", f, exp_v, act_v);
    end
  endtask

  initial begin
    errors = 0;
    reset_chain();
    foreach (tip[i]) tip[i] = '0;
    foreach (rows[i]) rows[i] = '0;
    count = 0;
    full = 0;
  end

  always @(posedge clk) begin
    out_item_t x, a;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) absorb(in_mon.data);
      if (out_mon.valid && out_mon.ready) begin
        a = out_mon.data;
        if (columns_q.size() == 0) begin
          errors++;
          $error("unexpected column %0d", a.column_index);
        end else begin
          x = columns_q.pop_front();
          cmp("column_index", x.column_index, a.column_index);
          cmp("lin_x", x.lin_x, a.lin_x);
          cmp("lin_y", x.lin_y, a.lin_y);
          cmp("lin_z", x.lin_z, a.lin_z);
          cmp("ang_x", x.ang_x, a.ang_x);
          cmp("ang_y", x.ang_y, a.ang_y);
          cmp("ang_z", x.ang_z, a.ang_z);
          cmp("saturated", x.saturated, a.saturated);
        end
      end
    end
  end
endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: regression bench for geometric_jacobian_columns
// Directed edge cases then random arm chains, with random stalls on both
// channels; a side checker predicts every column and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;
  import gjc_pkg::*;

  logic clk;
  logic rst_n;
  int   errors;
  int   pending;
  int   sent;
  bit   hold_sink;

  gjc_in_if  in_ch ();
  gjc_out_if out_ch ();

  geometric_jacobian_columns dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));
  gjc_chk chk (.clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
               .errors(errors), .pending(pending));

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // word with a bias toward extremes and small Q15.16 values
  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $urandom;
      default: return word_t'($signed($urandom_range(0, 262143)) - 131072);
    endcase
  endfunction

  // one transfer on the input channel, then an optional gap
  task automatic put(logic op, logic [1:0] jt, logic [1:0] ri,
                     word_t a, word_t b, word_t c, word_t d, bit idle);
    in_ch.valid <= 1'b1;
    in_ch.data <= '{op, jt, ri, a, b, c, d};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
    if (idle) begin
      repeat (gap()) begin
        in_ch.valid <= 1'b0;
        in_ch.data <= '{1'($urandom), 2'($urandom), 2'($urandom),
                        $urandom, $urandom, $urandom, $urandom};
        @(posedge clk);
      end
    end
  endtask

  task automatic put_row(logic [1:0] jt, logic [1:0] ri, bit idle);
    put(OP_ROW, jt, ri, rand_word(), rand_word(), rand_word(), rand_word(), idle);
  endtask

  task automatic put_joint(logic [1:0] jt, bit idle);
    for (int r = 0; r < 3; r++) put_row(jt, r[1:0], idle);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // result side: random back-pressure, with a long hold while hold_sink is set
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_sink) begin
        out_ch.ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_sink = 0;
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      if ($urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap() + 1) @(posedge clk);
      end
    end
  end

  initial begin
    int jt;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    sent = 0;
    hold_sink = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: identity chain, every joint type, extremes, row 3 noise
    put(OP_START, JT_PRISMATIC, 2'd0, 32'sh7fffffff, 32'sh80000000, 32'sh00010000, 0, 0);
    hold_sink = 1;  // sink holds off while joints keep coming
    put_joint(JT_REVOLUTE, 0);
    put_joint(JT_PRISMATIC, 0);
    put_joint(JT_CONSTANT, 0);
    put_joint(2'd3, 0);
    put(OP_ROW, JT_REVOLUTE, 2'd3, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0);
    put(OP_ROW, JT_REVOLUTE, 2'd0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
    put(OP_ROW, JT_REVOLUTE, 2'd1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0);
    put(OP_ROW, JT_REVOLUTE, 2'd2, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0);
    put_row(JT_PRISMATIC, 2'd2, 0);  // row 2 again reuses buffered rows
    drain();

    // random chains; now and then a long one aimed at the joint count limit
    while (sent < 430) begin
      put(OP_START, 2'($urandom), 2'($urandom), rand_word(), rand_word(), rand_word(),
          rand_word(), 1);
      if ($urandom_range(0, 15) == 0) hold_sink = 1;
      for (int j = ($urandom_range(0, 9) == 0) ? 70 : $urandom_range(1, 8); j > 0; j--) begin
        jt = $urandom_range(0, 9);
        if (jt == 9) put_row(2'($urandom), 2'd3, 1);
        else put_joint(jt < 4 ? JT_REVOLUTE : jt < 7 ? JT_PRISMATIC : 2'($urandom), 1);
        if (j == 70) hold_sink = 1;  // block fills and stalls its input
      end
      if ($urandom_range(0, 7) == 0) drain();
    end
    drain();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
